### src/lsrs_pkg.sv
// ----------------------------------------------------------------------------
// lsrs_pkg: least-served row scheduler package
// Sizes, word types and the controller/datapath interface structs.
// ----------------------------------------------------------------------------
package lsrs_pkg;

    localparam int ROWS          = 1024;
    localparam int COUNT_BITS    = 32;
    localparam int ROW_IDX_BITS  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int ROW_CNT_BITS  = $clog2(ROWS + 1);
    localparam int ENTRY_BITS    = COUNT_BITS + 1;

    localparam int RIU_BITS      = 11;
    localparam int OUT_ROW_BITS  = 10;
    localparam int OUT_PASS_BITS = 32;
    localparam int ADDR_BITS     = 3;
    localparam int DATA_BITS     = 32;

    localparam logic [RIU_BITS-1:0]  RIU_RESET    = 11'd1024;
    localparam logic [ADDR_BITS-3:0] REG_ROWS_IDX = 1'b0;

    typedef struct packed {
        logic                    has_finished;
        logic [OUT_ROW_BITS-1:0] finished_row;
    } in_word_t;

    typedef struct packed {
        logic                     grant_valid;
        logic [OUT_ROW_BITS-1:0]  granted_row;
        logic [OUT_PASS_BITS-1:0] granted_passes;
    } out_word_t;

    typedef struct packed {
        logic clear;
        logic load;
        logic fin_rd;
        logic fin_wr;
        logic scan;
        logic grant;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic fin_valid;
        logic scan_done;
    } dp_status_t;

endpackage

### src/least_served_row_scheduler_core.sv
// ----------------------------------------------------------------------------
// least_served_row_scheduler_core: least-served row scheduler
// Each request may report a finished row, then grants the free row with the
// fewest passes (lowest index on a tie) and marks it busy.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its grant word
// appears on grant for one cycle with grant_strobe, and must be taken then.
// The grant word follows the finish check, the finish update when the request
// reports a finished row, the scan of rows 0 to rows_in_use - 1 (rows_in_use
// capped at 1024; no rows when it is zero) and the grant write, and is
// registered. Busy is low while grant_strobe is high, so the next request can
// be taken at the edge that takes the grant word. The scan reads one row per
// cycle from the single read port of the row state memory, then drains the last
// read and compare. After reset busy stays high for a clearing pass that clears
// all 1024 rows, one per cycle; configuration writes are taken during it.
// ----------------------------------------------------------------------------
module least_served_row_scheduler_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [lsrs_pkg::ADDR_BITS-1:0]  paddr,
    input  logic [lsrs_pkg::DATA_BITS-1:0]  pwdata,
    output logic [lsrs_pkg::DATA_BITS-1:0]  prdata,
    output logic                            pready,
    input  logic                            start,
    output logic                            busy,
    input  lsrs_pkg::in_word_t              request,
    output logic                            grant_strobe,
    output lsrs_pkg::out_word_t             grant
);

    lsrs_pkg::ctrl_cmd_t  cmd;
    lsrs_pkg::dp_status_t status;

    assign pready = 1'b1;

    lsrs_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .status (status)
    );

    lsrs_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .request      (request),
        .cmd          (cmd),
        .status       (status),
        .grant_strobe (grant_strobe),
        .grant        (grant)
    );

endmodule

### src/lsrs_ram.sv
// ----------------------------------------------------------------------------
// lsrs_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module lsrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic                                       re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### src/lsrs_ctrl.sv
// ----------------------------------------------------------------------------
// lsrs_ctrl: scheduler controller
// Sequences the clearing pass, finish update, row scan and grant write.
// ----------------------------------------------------------------------------
module lsrs_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    output lsrs_pkg::ctrl_cmd_t   cmd,
    input  lsrs_pkg::dp_status_t  status
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FIN_RD,
        ST_FIN_WR,
        ST_SCAN,
        ST_GRANT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;
    logic   busy_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_FIN_RD;
                end
            end
            ST_FIN_RD:
            begin
                if (status.fin_valid)
                begin
                    cmd.fin_rd = 1'b1;
                    state_next = ST_FIN_WR;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_FIN_WR:
            begin
                cmd.fin_wr = 1'b1;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.scan_done)
                begin
                    state_next = ST_GRANT;
                end
            end
            ST_GRANT:
            begin
                cmd.grant  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
        busy_next = (state_next != ST_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            busy_reg  <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
        end
    end

    assign busy = busy_reg;

endmodule

### src/lsrs_dp.sv
// ----------------------------------------------------------------------------
// lsrs_dp: scheduler datapath
// Row state memory, configuration register, scan counter and best-row tracking.
// ----------------------------------------------------------------------------
module lsrs_dp (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [lsrs_pkg::ADDR_BITS-1:0]        paddr,
    input  logic [lsrs_pkg::DATA_BITS-1:0]        pwdata,
    output logic [lsrs_pkg::DATA_BITS-1:0]        prdata,
    input  lsrs_pkg::in_word_t                    request,
    input  lsrs_pkg::ctrl_cmd_t                   cmd,
    output lsrs_pkg::dp_status_t                  status,
    output logic                                  grant_strobe,
    output lsrs_pkg::out_word_t                   grant
);

    localparam int IB = lsrs_pkg::ROW_IDX_BITS;
    localparam int CB = lsrs_pkg::ROW_CNT_BITS;
    localparam int NB = lsrs_pkg::COUNT_BITS;

    logic [lsrs_pkg::RIU_BITS-1:0] riu_reg;
    logic [CB-1:0]                 active;

    logic [IB-1:0]  clr_idx_reg;
    logic [IB-1:0]  fin_idx_reg;
    logic           fin_ok_reg;
    logic [CB-1:0]  scan_idx_reg;
    logic [CB-1:0]  scan_idx_next;
    logic           pend_reg;
    logic           pend_next;
    logic [IB-1:0]  cmp_idx_reg;
    logic           found_reg;
    logic           found_next;
    logic [IB-1:0]  best_reg;
    logic [IB-1:0]  best_next;
    logic [NB-1:0]  best_passes_reg;
    logic [NB-1:0]  best_passes_next;
    logic           strobe_reg;
    lsrs_pkg::out_word_t grant_reg;

    logic                          ram_we;
    logic [IB-1:0]                 ram_waddr;
    logic [lsrs_pkg::ENTRY_BITS-1:0] ram_wdata;
    logic                          ram_re;
    logic [IB-1:0]                 ram_raddr;
    logic [lsrs_pkg::ENTRY_BITS-1:0] ram_rdata;

    logic          rd_busy;
    logic [NB-1:0] rd_passes;
    logic [NB-1:0] rd_passes_inc;
    logic          scan_issue;
    logic          cfg_wr;

    // configuration register
    assign cfg_wr = psel && penable && pwrite
        && (paddr[lsrs_pkg::ADDR_BITS-1:2] == lsrs_pkg::REG_ROWS_IDX);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            riu_reg <= lsrs_pkg::RIU_RESET;
        end
        else if (cfg_wr)
        begin
            riu_reg <= pwdata[lsrs_pkg::RIU_BITS-1:0];
        end
    end

    assign prdata = (paddr[lsrs_pkg::ADDR_BITS-1:2] == lsrs_pkg::REG_ROWS_IDX)
        ? lsrs_pkg::DATA_BITS'(riu_reg) : '0;

    assign active = (32'(riu_reg) > lsrs_pkg::ROWS) ? CB'(lsrs_pkg::ROWS) : CB'(riu_reg);

    // row state memory: {busy, passes}
    lsrs_ram #(
        .WIDTH (lsrs_pkg::ENTRY_BITS),
        .DEPTH (lsrs_pkg::ROWS)
    ) u_row_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_busy       = ram_rdata[NB];
    assign rd_passes     = ram_rdata[NB-1:0];
    assign rd_passes_inc = (rd_passes == '1) ? rd_passes : rd_passes + NB'(1);
    assign scan_issue    = cmd.scan && (scan_idx_reg < active);

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = clr_idx_reg;
        ram_wdata = '0;
        if (cmd.fin_wr)
        begin
            ram_we    = 1'b1;
            ram_waddr = fin_idx_reg;
            ram_wdata = {1'b0, rd_passes_inc};
        end
        else if (cmd.grant && found_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = best_reg;
            ram_wdata = {1'b1, best_passes_reg};
        end
        else if (cmd.clear)
        begin
            ram_we = 1'b1;
        end
    end

    assign ram_re    = cmd.fin_rd || scan_issue;
    assign ram_raddr = cmd.fin_rd ? fin_idx_reg : scan_idx_reg[IB-1:0];

    // scan and best-row tracking
    always_comb
    begin
        scan_idx_next    = scan_idx_reg;
        pend_next        = scan_issue;
        found_next       = found_reg;
        best_next        = best_reg;
        best_passes_next = best_passes_reg;
        if (cmd.load)
        begin
            scan_idx_next = '0;
            found_next    = 1'b0;
        end
        else
        begin
            if (scan_issue)
            begin
                scan_idx_next = scan_idx_reg + CB'(1);
            end
            if (pend_reg && !rd_busy && (!found_reg || rd_passes < best_passes_reg))
            begin
                found_next       = 1'b1;
                best_next        = cmp_idx_reg;
                best_passes_next = rd_passes;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_idx_reg  <= '0;
            fin_ok_reg   <= 1'b0;
            scan_idx_reg <= '0;
            pend_reg     <= 1'b0;
            found_reg    <= 1'b0;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                clr_idx_reg <= clr_idx_reg + IB'(1);
            end
            if (cmd.load)
            begin
                fin_ok_reg <= request.has_finished
                    && (32'(request.finished_row) < lsrs_pkg::ROWS);
            end
            scan_idx_reg <= scan_idx_next;
            pend_reg     <= pend_next;
            found_reg    <= found_next;
            strobe_reg   <= cmd.grant;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            fin_idx_reg <= IB'(request.finished_row);
        end
        cmp_idx_reg     <= scan_idx_reg[IB-1:0];
        best_reg        <= best_next;
        best_passes_reg <= best_passes_next;
        if (cmd.grant)
        begin
            grant_reg.grant_valid    <= found_reg;
            grant_reg.granted_row    <= found_reg
                ? lsrs_pkg::OUT_ROW_BITS'(best_reg) : '0;
            grant_reg.granted_passes <= found_reg
                ? lsrs_pkg::OUT_PASS_BITS'(best_passes_reg) : '0;
        end
    end

    assign status.clear_last = (clr_idx_reg == IB'(lsrs_pkg::ROWS - 1));
    assign status.fin_valid  = fin_ok_reg;
    assign status.scan_done  = (scan_idx_reg >= active) && !pend_reg;

    assign grant_strobe = strobe_reg;
    assign grant        = grant_reg;

    a_strobe_after_grant: assert property (@(posedge clk) disable iff (!rst_n)
        grant_strobe |-> $past(cmd.grant))
        else $error("grant strobe without grant command");

    a_pend_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> $past(cmd.scan))
        else $error("compare pending without scan read");

    a_no_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (grant_strobe && !grant.grant_valid)
            |-> (grant.granted_row == '0 && grant.granted_passes == '0))
        else $error("empty grant carries nonzero fields");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan |-> (scan_idx_reg <= active))
        else $error("scan index beyond rows in use");

endmodule
